// ===== src/bba_pkg.sv =====
// Shared types and constants for the bitmap block allocator.
`default_nettype none

package bba_pkg;

	// Payload field widths
	localparam int OPCODE_W = 2;
	localparam int AMOUNT_W = 6;
	localparam int BLOCK_W  = 7;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 8;

	// Request opcodes
	localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Register indexes
	localparam logic REG_SIZE = 1'b0;

	// Free-count chunk: bits counted per cycle
	localparam int CHUNK_W     = 8;
	localparam int CHUNK_CNT_W = 4;

	// Map update command from the sequencer
	typedef struct packed {
		logic set_en;   // mark one block used
		logic clr_en;   // mark one block free
		logic clr_all;  // free every block
	} map_cmd_t;

endpackage

`default_nettype wire

// ===== src/bba_map.sv =====
// Block usage bitmap with first-free search and chunked free count.
`default_nettype none

module bba_map #(
	parameter int MAX_BLOCKS = 128,
	parameter int IDX_W      = 7,
	parameter int SZ_W       = 8,
	parameter int CH_W       = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bba_pkg::map_cmd_t            cmd,
	input  wire logic [IDX_W-1:0]             idx,
	input  wire logic [SZ_W-1:0]              size,
	input  wire logic [CH_W-1:0]              chunk_sel,
	output logic      [IDX_W-1:0]             free_idx,
	output logic      [bba_pkg::CHUNK_CNT_W-1:0] chunk_cnt
);
	import bba_pkg::*;

	localparam int NCHUNK = (MAX_BLOCKS + CHUNK_W - 1) / CHUNK_W;
	localparam int PAD_W  = NCHUNK * CHUNK_W;

	logic [MAX_BLOCKS-1:0] used_q;
	logic [MAX_BLOCKS-1:0] fm;
	logic [PAD_W-1:0]      fm_pad;
	logic [CHUNK_W-1:0]    chunk_bits;

	// Map update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.clr_all) begin
			used_q <= '0;
		end else if (cmd.set_en) begin
			used_q[idx] <= 1'b1;
		end else if (cmd.clr_en) begin
			used_q[idx] <= 1'b0;
		end
	end

	// Free and managed blocks
	always_comb begin
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			fm[i] = !used_q[i] && (SZ_W'(i) < size);
		end
	end

	// Lowest free managed block
	always_comb begin
		free_idx = '0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (fm[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// Population count of one chunk
	assign fm_pad     = PAD_W'(fm);
	assign chunk_bits = fm_pad[chunk_sel * CHUNK_W +: CHUNK_W];

	always_comb begin
		chunk_cnt = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			chunk_cnt = chunk_cnt + CHUNK_CNT_W'(chunk_bits[i]);
		end
	end

endmodule

`default_nettype wire

// ===== src/bba_ctrl.sv =====
// Request sequencer: free-count pass, grant loop and result register.
`default_nettype none

module bba_ctrl #(
	parameter int MAX_BLOCKS = 128,
	parameter int MAX_RUN    = 32,
	parameter int IDX_W      = 7,
	parameter int SZ_W       = 8,
	parameter int CH_W       = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [SZ_W-1:0]                 size,
	// request channel
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic [bba_pkg::OPCODE_W-1:0]    opcode,
	input  wire logic [bba_pkg::AMOUNT_W-1:0]    amount,
	input  wire logic [bba_pkg::BLOCK_W-1:0]     block_number,
	// map interface
	output bba_pkg::map_cmd_t                    cmd,
	output logic      [IDX_W-1:0]                idx,
	output logic      [CH_W-1:0]                 chunk_sel,
	input  wire logic [IDX_W-1:0]                free_idx,
	input  wire logic [bba_pkg::CHUNK_CNT_W-1:0] chunk_cnt,
	// result channel
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output logic      [bba_pkg::BLOCK_W-1:0]     granted_block,
	output logic                                 last,
	output logic      [bba_pkg::STATUS_W-1:0]    status
);
	import bba_pkg::*;

	localparam int NCHUNK = (MAX_BLOCKS + CHUNK_W - 1) / CHUNK_W;
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int AW     = (CNT_W > AMOUNT_W) ? CNT_W : AMOUNT_W;
	localparam int BW     = (IDX_W > BLOCK_W) ? IDX_W : BLOCK_W;
	localparam int RW     = (SZ_W > BLOCK_W) ? SZ_W : BLOCK_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COUNT,
		S_CHECK,
		S_GRANT,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic [AMOUNT_W-1:0]   amount_q;
	logic [AMOUNT_W-1:0]   k_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CH_W-1:0]       chunk_q;
	logic [STATUS_W-1:0]   res_st_q;
	logic                  rsp_valid_q;
	logic [BLOCK_W-1:0]    granted_q;
	logic                  last_q;
	logic [STATUS_W-1:0]   status_q;

	logic                  accept;
	logic                  slot_free;
	logic                  rsp_load;
	logic [BW-1:0]         blk_w;
	logic                  in_range;
	logic                  too_long;
	logic                  grant_last;

	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign slot_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load   = ((state_q == S_GRANT) || (state_q == S_EMIT)) && slot_free;
	assign blk_w      = BW'(block_number);
	assign in_range   = RW'(block_number) < RW'(size);
	assign too_long   = {1'b0, amount} > 7'(MAX_RUN);
	assign grant_last = ({1'b0, k_q} + 7'd1) == {1'b0, amount_q};
	assign chunk_sel  = chunk_q;

	// Map commands
	always_comb begin
		cmd         = '0;
		idx         = IDX_W'(blk_w);
		cmd.clr_all = accept && (opcode == OP_CLEAR);
		cmd.clr_en  = accept && (opcode == OP_FREE) && in_range;
		if (state_q == S_GRANT) begin
			idx        = free_idx;
			cmd.set_en = slot_free;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			amount_q    <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			chunk_q     <= '0;
			res_st_q    <= ST_OK;
			granted_q   <= '0;
			last_q      <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						amount_q <= amount;
						k_q      <= '0;
						cnt_q    <= '0;
						chunk_q  <= '0;
						res_st_q <= ST_OK;
						case (opcode)
							OP_ALLOC: begin
								if (amount == '0) begin
									state_q <= S_EMIT;
								end else if (too_long) begin
									res_st_q <= ST_SHORT;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_COUNT;
								end
							end
							OP_FREE: begin
								res_st_q <= in_range ? ST_OK : ST_RANGE;
								state_q  <= S_EMIT;
							end
							OP_CLEAR: begin
								state_q <= S_EMIT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_COUNT: begin
					cnt_q   <= cnt_q + CNT_W'(chunk_cnt);
					chunk_q <= chunk_q + CH_W'(1);
					if (chunk_q == CH_W'(NCHUNK - 1)) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (AW'(cnt_q) < AW'(amount_q)) begin
						res_st_q <= ST_SHORT;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_GRANT;
					end
				end
				S_GRANT: begin
					if (slot_free) begin
						granted_q   <= BLOCK_W'(free_idx);
						last_q      <= grant_last;
						status_q    <= ST_OK;
						k_q         <= k_q + AMOUNT_W'(1);
						if (grant_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						granted_q   <= '0;
						last_q      <= 1'b1;
						status_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign granted_block = granted_q;
	assign last          = last_q;
	assign status        = status_q;

endmodule

`default_nettype wire

// ===== src/bitmap_block_allocator.sv =====
// Bitmap block allocator top level: register port, sequencer and usage map.
//
// Keeps one used bit per disk block and grants free blocks lowest number first.
// A free or clear request goes to the emit state, which loads its result into
// the output register once the output slot is free. An allocate of 1..MAX_RUN
// blocks first counts the free managed blocks eight bits per cycle, then
// compares the count with the request, then grants one block per cycle while
// the output slot is free, through a single priority encoder over the map; an
// allocate that is too long, or short of free blocks at the compare, ends with
// one failure result. The request channel stalls until the last result of the
// transaction is in the output register. The map is cleared by reset with no
// sweep. The managed-size register sits at byte address 0.
`default_nettype none

module bitmap_block_allocator #(
	parameter int MAX_BLOCKS = 128,
	parameter int MAX_RUN    = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	// request channel
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic [bba_pkg::OPCODE_W-1:0] opcode,
	input  wire logic [bba_pkg::AMOUNT_W-1:0] amount,
	input  wire logic [bba_pkg::BLOCK_W-1:0]  block_number,
	// result channel
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic      [bba_pkg::BLOCK_W-1:0]  granted_block,
	output logic                              last,
	output logic      [bba_pkg::STATUS_W-1:0] status
);
	import bba_pkg::*;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int SZ_W   = $clog2(MAX_BLOCKS + 1);
	localparam int NCHUNK = (MAX_BLOCKS + CHUNK_W - 1) / CHUNK_W;
	localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int CW     = (SZ_W > CFG_W) ? SZ_W : CFG_W;

	logic [CFG_W-1:0]  size_reg_q;
	logic [CW-1:0]     size_ext;
	logic [CW-1:0]     size_sat;
	logic [SZ_W-1:0]   size;
	logic              cfg_wr;
	map_cmd_t          cmd;
	logic [IDX_W-1:0]  idx;
	logic [CH_W-1:0]   chunk_sel;
	logic [IDX_W-1:0]  free_idx;
	logic [CHUNK_CNT_W-1:0] chunk_cnt;

	// Register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIZE);
	assign prdata = (paddr[2] == REG_SIZE) ? 32'(size_reg_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg_q <= 8'd128;
		end else if (cfg_wr) begin
			size_reg_q <= pwdata[CFG_W-1:0];
		end
	end

	// Managed size saturates at the map depth
	assign size_ext = CW'(size_reg_q);
	assign size_sat = (size_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : size_ext;
	assign size     = SZ_W'(size_sat);

	bba_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.MAX_RUN    (MAX_RUN),
		.IDX_W      (IDX_W),
		.SZ_W       (SZ_W),
		.CH_W       (CH_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.size          (size),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.opcode        (opcode),
		.amount        (amount),
		.block_number  (block_number),
		.cmd           (cmd),
		.idx           (idx),
		.chunk_sel     (chunk_sel),
		.free_idx      (free_idx),
		.chunk_cnt     (chunk_cnt),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.granted_block (granted_block),
		.last          (last),
		.status        (status)
	);

	bba_map #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.IDX_W      (IDX_W),
		.SZ_W       (SZ_W),
		.CH_W       (CH_W)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.size      (size),
		.chunk_sel (chunk_sel),
		.free_idx  (free_idx),
		.chunk_cnt (chunk_cnt)
	);

	// A request that produces results holds off the next one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (opcode != OP_NONE)) |=> req_stall)
		else $error("request channel open right after a transaction");

	// Failures are single, final results
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status != ST_OK)) |-> (last && (granted_block == '0)))
		else $error("failure result not final or carries a block");

	// At most one map update per cycle
	a_map_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.set_en, cmd.clr_en, cmd.clr_all}))
		else $error("conflicting map updates");

	// Grants only hit managed blocks
	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_en |-> (SZ_W'(idx) < size))
		else $error("grant outside managed range");

endmodule

`default_nettype wire
